### design/lamt_pkg.sv
`default_nettype none

package lamt_pkg;

    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths on the channels
    localparam int IN_VALUE_W = 32;
    localparam int STATUS_W   = 2;

    // Cells per selection group
    localparam int GROUP_SIZE = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_TAKEN    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic ins;   // shift toward higher positions and insert the key
        logic cmp;   // latch the candidate flag for a query
        logic take;  // set the taken mark where selected
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/lamt_req_if.sv
`default_nettype none

interface lamt_req_if import lamt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [IN_VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

### design/lamt_rsp_if.sv
`default_nettype none

interface lamt_rsp_if import lamt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [IN_VALUE_W-1:0] taken_value;

    modport source (output valid, output status, output taken_value, input ready);
    modport sink   (input valid, input status, input taken_value, output ready);
endinterface

`default_nettype wire

### design/lamt_cell.sv
`default_nettype none

module lamt_cell import lamt_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [VALUE_WIDTH-1:0] i_key,
    input  wire logic [VALUE_WIDTH-1:0] i_prev_val,
    input  wire logic                   i_prev_taken,
    input  wire logic                   i_prev_occ,
    input  wire logic                   i_prev_shift,
    input  wire logic                   i_sel,
    output logic [VALUE_WIDTH-1:0]      o_val,
    output logic                        o_taken,
    output logic                        o_occ,
    output logic                        o_shift,
    output logic                        o_cand
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_taken;
    logic                   r_occ;
    logic                   r_cand;

    // Empty cells and cells above the key move up on insert
    assign o_shift = !r_occ || (r_val > i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
            r_occ   <= 1'b0;
            r_cand  <= 1'b0;
        end else begin
            if (i_ctl.ins && o_shift) begin
                if (i_prev_shift) begin
                    r_val   <= i_prev_val;
                    r_taken <= i_prev_taken;
                    r_occ   <= i_prev_occ;
                end else begin
                    r_val   <= i_key;
                    r_taken <= 1'b0;
                    r_occ   <= 1'b1;
                end
            end
            if (i_ctl.cmp) begin
                r_cand <= r_occ && !r_taken && (r_val <= i_key);
            end
            if (i_ctl.take && i_sel) begin
                r_taken <= 1'b1;
            end
        end
    end

    assign o_val   = r_val;
    assign o_taken = r_taken;
    assign o_occ   = r_occ;
    assign o_cand  = r_cand;

endmodule

`default_nettype wire

### design/lamt_grp.sv
`default_nettype none

module lamt_grp import lamt_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [GROUP_SIZE-1:0]  i_cand,
    input  wire logic [VALUE_WIDTH-1:0] i_val [GROUP_SIZE],
    output logic [GROUP_SIZE-1:0]       o_sel,
    output logic                        o_any,
    output logic [VALUE_WIDTH-1:0]      o_val
);

    logic [GROUP_SIZE-1:0]  r_sel;
    logic                   r_any;
    logic [VALUE_WIDTH-1:0] r_val;

    logic [GROUP_SIZE-1:0]  n_sel;
    logic [VALUE_WIDTH-1:0] n_val;

    // Keep only the highest candidate of the group
    always_comb begin
        logic higher;
        higher = 1'b0;
        n_val  = '0;
        for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            n_sel[j] = i_cand[j] && !higher;
            higher   = higher || i_cand[j];
            if (n_sel[j]) begin
                n_val = n_val | i_val[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
            r_any <= |i_cand;
            r_val <= n_val;
        end
    end

    assign o_sel = r_sel;
    assign o_any = r_any;
    assign o_val = r_val;

endmodule

`default_nettype wire

### design/largest_at_most_take_table_core.sv
// Sorted multiset with taken marks, largest-at-most query.
//
// i_req carries req_type and value. An insert places value after any equal
// entries; a full table drops it with status "full". A query takes the largest
// untaken entry not above value and returns it, or reports none available.
// Every item gives exactly one item on o_rsp (status, taken_value).
//
// An insert is applied to the cells in the execute state. A query compares in
// every cell there, picks the top candidate per group of 32 cells in the pick
// state and the top group, setting its mark, in the take state. Results pass
// a holding register and the o_rsp register. One item is worked on at a time.
//
// Reset empties the table at once; no clearing pass is needed.
// A stalled o_rsp holds its item; one more finished result waits in a holding
// register, and i_req deasserts ready while busy or while that register cannot drain.
`default_nettype none

module largest_at_most_take_table_core import lamt_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lamt_req_if.sink    i_req,
    lamt_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NGRP  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_TAKE = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic                   r_req;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]       r_count;

    logic                   r_pend_valid;
    logic [STATUS_W-1:0]    r_pend_status;
    logic [VALUE_WIDTH-1:0] r_pend_val;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [VALUE_WIDTH-1:0] r_out_val;

    logic      full;
    logic      out_free;
    logic      accept;
    t_cell_ctl ctl;

    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]    w_taken;
    logic [CAPACITY-1:0]    w_occ;
    logic [CAPACITY-1:0]    w_shift;
    logic [CAPACITY-1:0]    w_cand;

    logic [NGRP-1:0][GROUP_SIZE-1:0] w_gsel;
    logic [NGRP-1:0]                 w_gany;
    logic [VALUE_WIDTH-1:0]          w_gval [NGRP];
    logic [NGRP-1:0]                 w_gtop;
    logic [VALUE_WIDTH-1:0]          pick_val;

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE) && (!r_pend_valid || out_free);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        ctl      = '0;
        ctl.ins  = (r_state == S_EXEC) && (r_req == REQ_INSERT) && !full;
        ctl.cmp  = (r_state == S_EXEC) && (r_req == REQ_QUERY);
        ctl.take = (r_state == S_TAKE);
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_val;
        logic                   prev_taken;
        logic                   prev_occ;
        logic                   prev_shift;

        if (i == 0) begin : g_head
            assign prev_val   = '0;
            assign prev_taken = 1'b0;
            assign prev_occ   = 1'b0;
            assign prev_shift = 1'b0;
        end else begin : g_link
            assign prev_val   = w_val[i-1];
            assign prev_taken = w_taken[i-1];
            assign prev_occ   = w_occ[i-1];
            assign prev_shift = w_shift[i-1];
        end

        lamt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_key        (r_key),
            .i_prev_val   (prev_val),
            .i_prev_taken (prev_taken),
            .i_prev_occ   (prev_occ),
            .i_prev_shift (prev_shift),
            .i_sel        (w_gsel[i / GROUP_SIZE][i % GROUP_SIZE] && w_gtop[i / GROUP_SIZE]),
            .o_val        (w_val[i]),
            .o_taken      (w_taken[i]),
            .o_occ        (w_occ[i]),
            .o_shift      (w_shift[i]),
            .o_cand       (w_cand[i])
        );
    end

    // Per-group selection
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [GROUP_SIZE-1:0]  cand;
        logic [VALUE_WIDTH-1:0] vals [GROUP_SIZE];

        for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_slot
            if (g * GROUP_SIZE + j < CAPACITY) begin : g_used
                assign cand[j] = w_cand[g * GROUP_SIZE + j];
                assign vals[j] = w_val[g * GROUP_SIZE + j];
            end else begin : g_pad
                assign cand[j] = 1'b0;
                assign vals[j] = '0;
            end
        end

        lamt_grp #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_grp (
            .i_clk  (i_clk),
            .i_en   (r_state == S_PICK),
            .i_cand (cand),
            .i_val  (vals),
            .o_sel  (w_gsel[g]),
            .o_any  (w_gany[g]),
            .o_val  (w_gval[g])
        );
    end

    // Highest group holding a candidate
    always_comb begin
        logic higher;
        higher   = 1'b0;
        pick_val = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            w_gtop[g] = w_gany[g] && !higher;
            higher    = higher || w_gany[g];
            if (w_gtop[g]) begin
                pick_val = pick_val | w_gval[g];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_req == REQ_QUERY) ? S_PICK : S_IDLE;
            end
            S_PICK: n_state = S_TAKE;
            S_TAKE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                r_req <= i_req.req_type;
                r_key <= VALUE_WIDTH'(i_req.value);
            end

            // Drain the holding register into the output register
            if (out_free) begin
                r_out_valid <= r_pend_valid;
                if (r_pend_valid) begin
                    r_out_status <= r_pend_status;
                    r_out_val    <= r_pend_val;
                end
            end
            if (out_free && r_pend_valid) begin
                r_pend_valid <= 1'b0;
            end

            if (r_state == S_EXEC && r_req == REQ_INSERT) begin
                r_pend_valid  <= 1'b1;
                r_pend_val    <= '0;
                r_pend_status <= full ? ST_FULL : ST_INSERTED;
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end

            if (r_state == S_TAKE) begin
                r_pend_valid  <= 1'b1;
                r_pend_status <= (|w_gany) ? ST_TAKEN : ST_NONE;
                r_pend_val    <= pick_val;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.taken_value = IN_VALUE_W'(r_out_val);

endmodule

`default_nettype wire

### tb/tb_largest_at_most_take_table_core.sv
`timescale 1ns / 100ps

module tb_largest_at_most_take_table_core import lamt_pkg::*; ();

    localparam int CAP          = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1680;
    localparam int PLAN_ROWS    = 25;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [IN_VALUE_W-1:0] taken_value;
    } table_rsp_t;

    typedef struct packed {
        logic                  req_type;
        logic [IN_VALUE_W-1:0] value;
        logic                  typed;
        logic [STATUS_W-1:0]   status;
        logic [IN_VALUE_W-1:0] taken_value;
    } plan_row_t;

    logic i_clk;
    logic i_rst_n;

    lamt_req_if req_if ();
    lamt_rsp_if rsp_if ();

    largest_at_most_take_table_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the table
    logic [IN_VALUE_W-1:0] tbl_val   [CAP];
    bit                    tbl_taken [CAP];
    int                    tbl_cnt;

    table_rsp_t outcome_q [$];

    int  errors;
    int  n_sent;
    int  n_taken, n_none, n_inserted, n_full;
    int  stall_left;
    bit  calm;

    // Directed sequence; untyped rows are read straight off the table, typed rows carry their result
    plan_row_t plan [PLAN_ROWS] = '{
        '{REQ_QUERY,  32'h0000_0000, 1'b1, ST_NONE,     32'h0000_0000},
        '{REQ_QUERY,  32'hFFFF_FFFF, 1'b1, ST_NONE,     32'h0000_0000},
        '{REQ_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED, 32'h0000_0000},
        '{REQ_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0000_0000},
        '{REQ_INSERT, 32'h0000_0005, 1'b1, ST_INSERTED, 32'h0000_0000},
        '{REQ_INSERT, 32'h0000_0005, 1'b1, ST_INSERTED, 32'h0000_0000},
        '{REQ_QUERY,  32'h0000_0004, 1'b1, ST_TAKEN,    32'h0000_0000},
        '{REQ_QUERY,  32'h0000_0000, 1'b1, ST_NONE,     32'h0000_0000},
        '{REQ_QUERY,  32'h0000_0005, 1'b1, ST_TAKEN,    32'h0000_0005},
        '{REQ_QUERY,  32'h0000_0005, 1'b1, ST_TAKEN,    32'h0000_0005},
        '{REQ_QUERY,  32'h0000_0005, 1'b1, ST_NONE,     32'h0000_0000},
        '{REQ_QUERY,  32'hFFFF_FFFE, 1'b1, ST_NONE,     32'h0000_0000},
        '{REQ_QUERY,  32'hFFFF_FFFF, 1'b1, ST_TAKEN,    32'hFFFF_FFFF},
        '{REQ_QUERY,  32'hFFFF_FFFF, 1'b1, ST_NONE,     32'h0000_0000},
        '{REQ_INSERT, 32'h8000_0000, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_INSERT, 32'h7FFF_FFFF, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_INSERT, 32'h5555_5555, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_INSERT, 32'hAAAA_AAAA, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_QUERY,  32'h9000_0000, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_QUERY,  32'hFFFF_FFFF, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_INSERT, 32'h0000_0007, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_QUERY,  32'h0000_0006, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_QUERY,  32'h7FFF_FFFF, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_INSERT, 32'h0000_0001, 1'b0, ST_TAKEN,    32'h0000_0000},
        '{REQ_QUERY,  32'h0000_0001, 1'b0, ST_TAKEN,    32'h0000_0000}
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Insert or take on the shadow table and return the outcome
    function automatic table_rsp_t apply_to_table(input logic rt,
                                                  input logic [IN_VALUE_W-1:0] v);
        int         lo, hi, mid, k;
        table_rsp_t r;
        r  = '0;
        lo = 0;
        hi = tbl_cnt;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_val[mid] > v)
                hi = mid;
            else
                lo = mid + 1;
        end
        if (rt == REQ_INSERT) begin
            if (tbl_cnt >= CAP) begin
                r.status = ST_FULL;
            end else begin
                for (k = tbl_cnt; k > lo; k--) begin
                    tbl_val[k]   = tbl_val[k-1];
                    tbl_taken[k] = tbl_taken[k-1];
                end
                tbl_val[lo]   = v;
                tbl_taken[lo] = 1'b0;
                tbl_cnt++;
                r.status = ST_INSERTED;
            end
        end else begin
            while (lo > 0 && tbl_taken[lo-1])
                lo--;
            if (lo == 0) begin
                r.status = ST_NONE;
            end else begin
                tbl_taken[lo-1] = 1'b1;
                r.status        = ST_TAKEN;
                r.taken_value   = tbl_val[lo-1];
            end
        end
        return r;
    endfunction

    // Length of one idle stretch: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_item(input logic rt, input logic [IN_VALUE_W-1:0] v,
                             input logic typed, input logic [STATUS_W-1:0] st,
                             input logic [IN_VALUE_W-1:0] tv);
        int         gap;
        table_rsp_t outcome;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 40)
            gap = idle_len();
        if ($urandom_range(0, 149) == 0)
            calm <= ~calm;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rt;
        req_if.value    <= v;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        outcome = apply_to_table(rt, v);
        if (typed)
            outcome = {st, tv};
        outcome_q = {outcome_q, outcome};
        n_sent++;
    endtask

    // Receiver: random backpressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= idle_len() - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_rsp
        table_rsp_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with nothing pending: status=%0d value=%h",
                         $time, rsp_if.status, rsp_if.taken_value);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.taken_value !== want.taken_value) begin
                    $display("%0t: taken_value expected %h, got %h",
                             $time, want.taken_value, rsp_if.taken_value);
                    errors++;
                end
                case (want.status)
                    ST_TAKEN:    n_taken++;
                    ST_NONE:     n_none++;
                    ST_INSERTED: n_inserted++;
                    default:     n_full++;
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_largest_at_most_take_table_core failed");
        $finish;
    end

    initial begin : stimulus
        int                    i, sel;
        logic                  rt;
        logic [IN_VALUE_W-1:0] v;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_INSERT;
        req_if.value    = '0;
        rsp_if.ready    = 1'b0;
        stall_left      = 0;
        calm            = 1'b0;
        errors          = 0;
        n_sent          = 0;
        n_taken         = 0;
        n_none          = 0;
        n_inserted      = 0;
        n_full          = 0;
        tbl_cnt         = 0;
        for (i = 0; i < CAP; i++) begin
            tbl_val[i]   = '0;
            tbl_taken[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < PLAN_ROWS; i++)
            send_item(plan[i].req_type, plan[i].value, plan[i].typed,
                      plan[i].status, plan[i].taken_value);

        // Fill the table mostly with inserts, then hammer it full
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (tbl_cnt < CAP)
                rt = ($urandom_range(0, 99) < 75) ? REQ_INSERT : REQ_QUERY;
            else
                rt = ($urandom_range(0, 99) < 40) ? REQ_INSERT : REQ_QUERY;
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                v = $urandom_range(0, 63);
            end else if (sel < 40) begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hFFFF_FFFE;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end else if (sel < 60 && rt == REQ_QUERY && tbl_cnt > 0) begin
                // aim at a stored value, or just around it
                v = tbl_val[$urandom_range(0, tbl_cnt - 1)];
                case ($urandom_range(0, 3))
                    0:       v = v - 1;
                    1:       v = v + 1;
                    default: ;
                endcase
            end else begin
                v = $urandom;
            end
            send_item(rt, v, 1'b0, ST_TAKEN, '0);
        end
        req_if.valid <= 1'b0;

        while (outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items sent; results: %0d taken, %0d none, %0d inserted, %0d full",
                 n_sent, n_taken, n_none, n_inserted, n_full);
        $display("table held %0d of %0d entries at the end", tbl_cnt, CAP);
        if (errors == 0) begin
            $display("tb_largest_at_most_take_table_core passed");
        end else begin
            $display("tb_largest_at_most_take_table_core failed");
        end
        $finish;
    end

endmodule
